// File: design/psi_pkg.sv
// ----------------------------------------------------------------------------
// psi_pkg
// Shared types and codes for the pulse safety interlock: operation and
// start-outcome codes, the one-hot mode encoding, item and config structs.
// ----------------------------------------------------------------------------
package psi_pkg;

   // Operation codes carried by an input item
   typedef enum logic [2:0] {
      OP_ARM    = 3'd0,
      OP_START  = 3'd1,
      OP_TICK   = 3'd2,
      OP_FINISH = 3'd3,
      OP_ESTOP  = 3'd4,
      OP_FAULT  = 3'd5
   } op_type;

   // Start outcome codes, in check order
   typedef enum logic [3:0] {
      SC_ACCEPTED  = 4'd0,
      SC_ESTOP     = 4'd1,
      SC_BUSY      = 4'd2,
      SC_NOT_ARMED = 4'd3,
      SC_COOLDOWN  = 4'd4,
      SC_SENSOR    = 4'd5,
      SC_TOTAL     = 4'd6,
      SC_VERIF     = 4'd7,
      SC_DIAG      = 4'd8
   } start_code_type;

   // Interlock mode, one-hot
   typedef enum logic [5:0] {
      MODE_UNARMED  = 6'b000001,
      MODE_ARMED    = 6'b000010,
      MODE_PULSING  = 6'b000100,
      MODE_COOLDOWN = 6'b001000,
      MODE_FAULTED  = 6'b010000,
      MODE_ESTOPPED = 6'b100000
   } mode_type;

   // Mode codes as reported in a result item
   localparam logic [2:0] MC_UNARMED  = 3'd0;
   localparam logic [2:0] MC_ARMED    = 3'd1;
   localparam logic [2:0] MC_PULSING  = 3'd2;
   localparam logic [2:0] MC_COOLDOWN = 3'd3;
   localparam logic [2:0] MC_FAULTED  = 3'd4;
   localparam logic [2:0] MC_ESTOPPED = 3'd5;

   // Configuration register indexes
   localparam logic [2:0] CSR_PULSE_LENGTH   = 3'd0;
   localparam logic [2:0] CSR_HARD_TIMEOUT   = 3'd1;
   localparam logic [2:0] CSR_COOLDOWN       = 3'd2;
   localparam logic [2:0] CSR_TOTAL_BUDGET   = 3'd3;
   localparam logic [2:0] CSR_DIAG_BUDGET    = 3'd4;
   localparam logic [2:0] CSR_VERIF_BUDGET   = 3'd5;

   typedef struct packed {
      logic [31:0] pulse_length_ms;
      logic [31:0] max_run_ms;
      logic [31:0] cooldown_length_ms;
      logic [15:0] total_budget;
      logic [15:0] diagnostic_budget;
      logic [15:0] verification_budget;
   } cfg_type;

   // Mode, latched flags and per-arming counts (times live in the top level)
   typedef struct packed {
      mode_type    mode;
      logic        estop_latch;
      logic        tripped;
      logic        timed_out;
      logic [15:0] total_count;
      logic [15:0] diagnostic_count;
      logic [15:0] verification_count;
   } state_type;

   typedef struct packed {
      logic [2:0]  op;
      logic        profile_ok;
      logic        stop_released;
      logic        probe_kind;
      logic [31:0] now_ms;
      logic        sensor_ok;
      logic [15:0] current_measured;
      logic [15:0] current_ceiling;
      logic        stop_pressed;
   } req_item_type;

   typedef struct packed {
      logic        ok;
      logic [3:0]  start_code;
      logic [2:0]  mode_now;
      logic        tripped_flag;
      logic        timeout_flag;
      logic        estop_flag;
   } rsp_item_type;

   // One-hot mode to reported code
   function automatic logic [2:0] mode_code(input mode_type m);
      logic [2:0] c;
      case (m)
         MODE_UNARMED:  c = MC_UNARMED;
         MODE_ARMED:    c = MC_ARMED;
         MODE_PULSING:  c = MC_PULSING;
         MODE_COOLDOWN: c = MC_COOLDOWN;
         MODE_FAULTED:  c = MC_FAULTED;
         MODE_ESTOPPED: c = MC_ESTOPPED;
         default:       c = MC_UNARMED;
      endcase
      return c;
   endfunction

endpackage

// File: design/psi_csr.sv
// ----------------------------------------------------------------------------
// psi_csr
// Configuration register file: six write-only registers, all cleared by reset.
// ----------------------------------------------------------------------------
module psi_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   output psi_pkg::cfg_type cfg
);
   import psi_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode one register write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PULSE_LENGTH: cfg_in.pulse_length_ms     = csr_wdata;
            CSR_HARD_TIMEOUT: cfg_in.max_run_ms          = csr_wdata;
            CSR_COOLDOWN:     cfg_in.cooldown_length_ms  = csr_wdata;
            CSR_TOTAL_BUDGET: cfg_in.total_budget        = csr_wdata[15:0];
            CSR_DIAG_BUDGET:  cfg_in.diagnostic_budget   = csr_wdata[15:0];
            CSR_VERIF_BUDGET: cfg_in.verification_budget = csr_wdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/psi_eval.sv
// ----------------------------------------------------------------------------
// psi_eval
// Single-pass decision logic: from the current state and one item, the next
// state, the next timestamps and the result item.
// ----------------------------------------------------------------------------
module psi_eval #(
   parameter int TIME_BITS = 32
) (
   input  psi_pkg::req_item_type   item,
   input  psi_pkg::cfg_type        cfg,
   input  psi_pkg::state_type      cur,
   input  logic [TIME_BITS-1:0]    pulse_start,
   input  logic [TIME_BITS-1:0]    cooldown_start,
   output psi_pkg::state_type      nxt,
   output logic [TIME_BITS-1:0]    pulse_start_nxt,
   output logic [TIME_BITS-1:0]    cooldown_start_nxt,
   output psi_pkg::rsp_item_type   result
);
   import psi_pkg::*;

   // compare width covers both elapsed times and 32-bit limits
   localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

   logic [CW-1:0]        now_wide;
   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] run_el;
   logic [TIME_BITS-1:0] cool_el;
   logic                 cool_short;
   logic                 run_timeout;
   logic                 run_done;
   logic                 ok;
   start_code_type       code;

   // wrapped elapsed times
   assign now_wide    = CW'(item.now_ms);
   assign now_t       = now_wide[TIME_BITS-1:0];
   assign run_el      = now_t - pulse_start;
   assign cool_el     = now_t - cooldown_start;
   assign cool_short  = CW'(cool_el) < CW'(cfg.cooldown_length_ms);
   assign run_timeout = CW'(run_el) >= CW'(cfg.max_run_ms);
   assign run_done    = CW'(run_el) >= CW'(cfg.pulse_length_ms);

   // mode machine
   always_comb begin
      nxt                = cur;
      pulse_start_nxt    = pulse_start;
      cooldown_start_nxt = cooldown_start;
      ok                 = 1'b0;
      code               = SC_ACCEPTED;
      case (item.op)
         OP_ARM: begin
            if (item.profile_ok && item.stop_released && !cur.estop_latch &&
                cur.mode != MODE_FAULTED) begin
               nxt.mode               = MODE_ARMED;
               nxt.total_count        = '0;
               nxt.diagnostic_count   = '0;
               nxt.verification_count = '0;
               nxt.tripped            = 1'b0;
               nxt.timed_out          = 1'b0;
               ok                     = 1'b1;
            end
         end
         OP_START: begin
            if (cur.estop_latch) begin
               code = SC_ESTOP;
            end else if (cur.mode == MODE_PULSING) begin
               code = SC_BUSY;
            end else if (cur.mode != MODE_ARMED && cur.mode != MODE_COOLDOWN) begin
               code = SC_NOT_ARMED;
            end else if (cur.mode == MODE_COOLDOWN && cool_short) begin
               code = SC_COOLDOWN;
            end else if (!item.sensor_ok) begin
               code = SC_SENSOR;
            end else if (cur.total_count >= cfg.total_budget) begin
               code = SC_TOTAL;
            end else if (item.probe_kind &&
                         cur.verification_count >= cfg.verification_budget) begin
               code = SC_VERIF;
            end else if (!item.probe_kind &&
                         cur.diagnostic_count >= cfg.diagnostic_budget) begin
               code = SC_DIAG;
            end else begin
               nxt.total_count = cur.total_count + 16'd1;
               if (item.probe_kind) begin
                  nxt.verification_count = cur.verification_count + 16'd1;
               end else begin
                  nxt.diagnostic_count = cur.diagnostic_count + 16'd1;
               end
               nxt.mode        = MODE_PULSING;
               pulse_start_nxt = now_t;
               nxt.tripped     = 1'b0;
               nxt.timed_out   = 1'b0;
            end
         end
         OP_TICK: begin
            if (item.stop_pressed) begin
               nxt.estop_latch = 1'b1;
               nxt.mode        = MODE_ESTOPPED;
            end else if (cur.mode == MODE_PULSING) begin
               if (item.current_measured > item.current_ceiling) begin
                  nxt.tripped = 1'b1;
                  nxt.mode    = MODE_FAULTED;
               end else if (run_timeout) begin
                  nxt.timed_out = 1'b1;
                  nxt.mode      = MODE_FAULTED;
               end else if (run_done) begin
                  nxt.mode           = MODE_COOLDOWN;
                  cooldown_start_nxt = now_t;
               end else begin
                  ok = 1'b1;
               end
            end
         end
         OP_FINISH: begin
            if (cur.mode == MODE_PULSING) begin
               nxt.mode           = MODE_COOLDOWN;
               cooldown_start_nxt = now_t;
            end
         end
         OP_ESTOP: begin
            nxt.estop_latch = 1'b1;
            nxt.mode        = MODE_ESTOPPED;
         end
         OP_FAULT: begin
            nxt.tripped = 1'b1;
            nxt.mode    = MODE_FAULTED;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   // result reports the state after the item
   always_comb begin
      result.ok           = ok;
      result.start_code   = code;
      result.mode_now     = mode_code(nxt.mode);
      result.tripped_flag = nxt.tripped;
      result.timeout_flag = nxt.timed_out;
      result.estop_flag   = nxt.estop_latch;
   end

endmodule

// File: design/pulse_safety_interlock.sv
// ----------------------------------------------------------------------------
// pulse_safety_interlock
// Safety interlock for a pulsed probe: gates arm, start, tick, finish,
// e-stop and fault events against mode, budgets, timers and sensor state.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  op, timestamps, sensor inputs
//   rsp      out        rsp_valid / rsp_stall  ok, start_code, mode, flags
//   csr      in         csr_we                 csr_index, csr_wdata
//
// One item per cycle sustained while rsp_stall is low; an item passes the input
// register, then the single decision pass, then the result register.
// Reset is synchronous: mode unarmed, flags, counts, times and registers 0.
// A stalled result holds the result register; the input register keeps
// taking items until it is full, then req_stall rises in the same cycle.
// ----------------------------------------------------------------------------
module pulse_safety_interlock #(
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic        req_profile_ok,
   input  logic        req_stop_released,
   input  logic        req_probe_kind,
   input  logic [31:0] req_now_ms,
   input  logic        req_sensor_ok,
   input  logic [15:0] req_current_measured,
   input  logic [15:0] req_current_ceiling,
   input  logic        req_stop_pressed,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic [3:0]  rsp_start_code,
   output logic [2:0]  rsp_mode_now,
   output logic        rsp_tripped_flag,
   output logic        rsp_timeout_flag,
   output logic        rsp_estop_flag,
   // configuration
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import psi_pkg::*;

   cfg_type              cfg;
   req_item_type         req_item;
   req_item_type         item_ff;
   logic                 item_valid_ff;
   logic                 item_valid_in;
   rsp_item_type         rsp_ff;
   rsp_item_type         rsp_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   state_type            state_ff;
   state_type            state_in;
   logic [TIME_BITS-1:0] pulse_start_ff;
   logic [TIME_BITS-1:0] pulse_start_in;
   logic [TIME_BITS-1:0] cooldown_start_ff;
   logic [TIME_BITS-1:0] cooldown_start_in;
   logic                 advance;
   logic                 fire;
   logic                 req_take;

   psi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Handshake: result register frees when empty or taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = item_valid_ff && advance;
   assign req_stall = item_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      req_item.op               = req_op;
      req_item.profile_ok       = req_profile_ok;
      req_item.stop_released    = req_stop_released;
      req_item.probe_kind       = req_probe_kind;
      req_item.now_ms           = req_now_ms;
      req_item.sensor_ok        = req_sensor_ok;
      req_item.current_measured = req_current_measured;
      req_item.current_ceiling  = req_current_ceiling;
      req_item.stop_pressed     = req_stop_pressed;
   end

   // Input register valid
   always_comb begin
      if (req_take) begin
         item_valid_in = 1'b1;
      end else if (fire) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_item;
      end
   end

   // Decision pass
   psi_eval #(
      .TIME_BITS (TIME_BITS)
   ) u_eval (
      .item               (item_ff),
      .cfg                (cfg),
      .cur                (state_ff),
      .pulse_start        (pulse_start_ff),
      .cooldown_start     (cooldown_start_ff),
      .nxt                (state_in),
      .pulse_start_nxt    (pulse_start_in),
      .cooldown_start_nxt (cooldown_start_in),
      .result             (rsp_in)
   );

   assign rsp_valid_in = advance ? item_valid_ff : rsp_valid_ff;

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         state_ff          <= '{mode: MODE_UNARMED, default: '0};
         pulse_start_ff    <= '0;
         cooldown_start_ff <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (fire) begin
            state_ff          <= state_in;
            pulse_start_ff    <= pulse_start_in;
            cooldown_start_ff <= cooldown_start_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ff.ok;
   assign rsp_start_code   = rsp_ff.start_code;
   assign rsp_mode_now     = rsp_ff.mode_now;
   assign rsp_tripped_flag = rsp_ff.tripped_flag;
   assign rsp_timeout_flag = rsp_ff.timeout_flag;
   assign rsp_estop_flag   = rsp_ff.estop_flag;

   // estopped mode always carries the latch; a later fault op may move a
   // latched interlock on to faulted
   a_estop_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         ((rsp_ff.mode_now == MC_ESTOPPED) ? rsp_ff.estop_flag :
          (!rsp_ff.estop_flag || rsp_ff.mode_now == MC_FAULTED)))
      else $error("estop flag and mode disagree");

   // ok only while armed or pulsing, and never with a start refusal
   a_ok_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.ok) |->
         ((rsp_ff.mode_now == MC_ARMED || rsp_ff.mode_now == MC_PULSING) &&
          rsp_ff.start_code == SC_ACCEPTED))
      else $error("ok reported in wrong mode");

   // timeout flag implies a fault or a later e-stop
   a_timeout_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.timeout_flag) |->
         (rsp_ff.mode_now == MC_FAULTED || rsp_ff.mode_now == MC_ESTOPPED))
      else $error("timeout flag outside faulted mode");

   // state moves only when an item passes to the result register
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(state_ff))
      else $error("state changed without an item");

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: pulse safety interlock testbench
// Drives arm/start/tick/finish/e-stop/fault items through the interlock and
// checks every result item against a cycle-free model of the mode machine,
// budgets and wrapped timers. A directed opening is followed by random
// phases under several register settings. The run ends by driving the
// interlock into one of its terminal fault modes and then into e-stop.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import psi_pkg::*;

   // unused operation codes (no name in the package)
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   // --------------------------------------------------------------------------
   // Interlock model and expected-result store
   // --------------------------------------------------------------------------
   class interlock_scoreboard;
      cfg_type      regs;
      logic [2:0]   mode;
      logic         estop_latch;
      logic         tripped;
      logic         timed_out;
      logic [15:0]  total_count;
      logic [15:0]  diag_count;
      logic [15:0]  verif_count;
      logic [31:0]  pulse_t0;
      logic [31:0]  cool_t0;
      rsp_item_type outcome_q[$];
      int           failures;

      function new();
         regs        = '0;
         mode        = MC_UNARMED;
         estop_latch = 1'b0;
         tripped     = 1'b0;
         timed_out   = 1'b0;
         total_count = '0;
         diag_count  = '0;
         verif_count = '0;
         pulse_t0    = '0;
         cool_t0     = '0;
         failures    = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] data);
         case (idx)
            CSR_PULSE_LENGTH: regs.pulse_length_ms     = data;
            CSR_HARD_TIMEOUT: regs.max_run_ms          = data;
            CSR_COOLDOWN:     regs.cooldown_length_ms  = data;
            CSR_TOTAL_BUDGET: regs.total_budget        = data[15:0];
            CSR_DIAG_BUDGET:  regs.diagnostic_budget   = data[15:0];
            CSR_VERIF_BUDGET: regs.verification_budget = data[15:0];
            default: ;
         endcase
      endfunction

      function void enter_cooldown(logic [31:0] now);
         mode    = MC_COOLDOWN;
         cool_t0 = now;
      endfunction

      function void latch_estop();
         estop_latch = 1'b1;
         mode        = MC_ESTOPPED;
      endfunction

      // start checks, in priority order
      function start_code_type try_start(req_item_type it);
         logic [31:0] idle_ms;
         idle_ms = it.now_ms - cool_t0;
         if (estop_latch) return SC_ESTOP;
         if (mode == MC_PULSING) return SC_BUSY;
         if (mode != MC_ARMED && mode != MC_COOLDOWN) return SC_NOT_ARMED;
         if (mode == MC_COOLDOWN && idle_ms < regs.cooldown_length_ms) return SC_COOLDOWN;
         if (!it.sensor_ok) return SC_SENSOR;
         if (total_count >= regs.total_budget) return SC_TOTAL;
         if (it.probe_kind && verif_count >= regs.verification_budget) return SC_VERIF;
         if (!it.probe_kind && diag_count >= regs.diagnostic_budget) return SC_DIAG;
         total_count++;
         if (it.probe_kind) verif_count++;
         else diag_count++;
         mode      = MC_PULSING;
         pulse_t0  = it.now_ms;
         tripped   = 1'b0;
         timed_out = 1'b0;
         return SC_ACCEPTED;
      endfunction

      // returns 1 while the pulse carries on
      function logic run_tick(req_item_type it);
         logic [31:0] run_ms;
         run_ms = it.now_ms - pulse_t0;
         if (it.stop_pressed) begin
            latch_estop();
            return 1'b0;
         end
         if (mode != MC_PULSING) return 1'b0;
         if (it.current_measured > it.current_ceiling) begin
            tripped = 1'b1;
            mode    = MC_FAULTED;
            return 1'b0;
         end
         if (run_ms >= regs.max_run_ms) begin
            timed_out = 1'b1;
            mode      = MC_FAULTED;
            return 1'b0;
         end
         if (run_ms >= regs.pulse_length_ms) begin
            enter_cooldown(it.now_ms);
            return 1'b0;
         end
         return 1'b1;
      endfunction

      // accepted input item: advance the model and queue its result
      function void note_item(req_item_type it);
         rsp_item_type r;
         r = '0;
         case (it.op)
            OP_ARM: begin
               if (it.profile_ok && it.stop_released && !estop_latch &&
                   mode != MC_FAULTED) begin
                  mode        = MC_ARMED;
                  total_count = '0;
                  diag_count  = '0;
                  verif_count = '0;
                  tripped     = 1'b0;
                  timed_out   = 1'b0;
                  r.ok        = 1'b1;
               end
            end
            OP_START:  r.start_code = try_start(it);
            OP_TICK:   r.ok = run_tick(it);
            OP_FINISH: if (mode == MC_PULSING) enter_cooldown(it.now_ms);
            OP_ESTOP:  latch_estop();
            OP_FAULT: begin
               tripped = 1'b1;
               mode    = MC_FAULTED;
            end
            default: ;
         endcase
         r.mode_now     = mode;
         r.tripped_flag = tripped;
         r.timeout_flag = timed_out;
         r.estop_flag   = estop_latch;
         outcome_q.push_back(r);
      endfunction

      function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (outcome_q.size() == 0) begin
            $error("result item with no outcome pending");
            failures++;
            return;
         end
         want = outcome_q.pop_front();
         cmp_field("ok", 32'(want.ok), 32'(got.ok));
         cmp_field("start_code", 32'(want.start_code), 32'(got.start_code));
         cmp_field("mode_now", 32'(want.mode_now), 32'(got.mode_now));
         cmp_field("tripped_flag", 32'(want.tripped_flag), 32'(got.tripped_flag));
         cmp_field("timeout_flag", 32'(want.timeout_flag), 32'(got.timeout_flag));
         cmp_field("estop_flag", 32'(want.estop_flag), 32'(got.estop_flag));
      endfunction

      function int pending();
         return outcome_q.size();
      endfunction
   endclass

   // --------------------------------------------------------------------------
   // Signals and block
   // --------------------------------------------------------------------------
   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_op = '0;
   logic        req_profile_ok = 1'b0;
   logic        req_stop_released = 1'b0;
   logic        req_probe_kind = 1'b0;
   logic [31:0] req_now_ms = '0;
   logic        req_sensor_ok = 1'b0;
   logic [15:0] req_current_measured = '0;
   logic [15:0] req_current_ceiling = '0;
   logic        req_stop_pressed = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_ok;
   logic [3:0]  rsp_start_code;
   logic [2:0]  rsp_mode_now;
   logic        rsp_tripped_flag;
   logic        rsp_timeout_flag;
   logic        rsp_estop_flag;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   interlock_scoreboard sb = new();

   logic [31:0] clock_ms = '0;     // stimulus time base
   int unsigned gap_pct = 0;       // sender idle odds per item
   int unsigned stall_pct = 0;     // receiver stall odds per cycle
   logic        hold_request = 1'b0;

   pulse_safety_interlock i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_op               (req_op),
      .req_profile_ok       (req_profile_ok),
      .req_stop_released    (req_stop_released),
      .req_probe_kind       (req_probe_kind),
      .req_now_ms           (req_now_ms),
      .req_sensor_ok        (req_sensor_ok),
      .req_current_measured (req_current_measured),
      .req_current_ceiling  (req_current_ceiling),
      .req_stop_pressed     (req_stop_pressed),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_ok               (rsp_ok),
      .rsp_start_code       (rsp_start_code),
      .rsp_mode_now         (rsp_mode_now),
      .rsp_tripped_flag     (rsp_tripped_flag),
      .rsp_timeout_flag     (rsp_timeout_flag),
      .rsp_estop_flag       (rsp_estop_flag),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Result side: check accepted items, stall in bursts or one long hold
   // --------------------------------------------------------------------------
   initial begin : rsp_side
      int           stall_left;
      logic         hold_taken;
      rsp_item_type got;
      stall_left = 0;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            got.ok           = rsp_ok;
            got.start_code   = rsp_start_code;
            got.mode_now     = rsp_mode_now;
            got.tripped_flag = rsp_tripped_flag;
            got.timeout_flag = rsp_timeout_flag;
            got.estop_flag   = rsp_estop_flag;
            sb.check_result(got);
         end
         if (stall_left > 0) begin
            stall_left--;
         end else if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = 150;
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = int'($urandom_range(1, 5));
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   // --------------------------------------------------------------------------
   // Driving tasks
   // --------------------------------------------------------------------------
   task automatic send_item(input req_item_type it);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_op               <= it.op;
      req_profile_ok       <= it.profile_ok;
      req_stop_released    <= it.stop_released;
      req_probe_kind       <= it.probe_kind;
      req_now_ms           <= it.now_ms;
      req_sensor_ok        <= it.sensor_ok;
      req_current_measured <= it.current_measured;
      req_current_ceiling  <= it.current_ceiling;
      req_stop_pressed     <= it.stop_pressed;
      do @(posedge clock); while (req_stall);
      sb.note_item(it);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic set_config(input logic [31:0] len_ms, input logic [31:0] limit_ms,
                             input logic [31:0] rest_ms, input logic [15:0] total,
                             input logic [15:0] diag, input logic [15:0] verif);
      write_csr(CSR_PULSE_LENGTH, len_ms);
      write_csr(CSR_HARD_TIMEOUT, limit_ms);
      write_csr(CSR_COOLDOWN, rest_ms);
      write_csr(CSR_TOTAL_BUDGET, {16'd0, total});
      write_csr(CSR_DIAG_BUDGET, {16'd0, diag});
      write_csr(CSR_VERIF_BUDGET, {16'd0, verif});
      csr_we <= 1'b0;
   endtask

   // block idle: every outcome back, plus the pipeline depth
   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic req_item_type base_item(logic [2:0] op, logic [31:0] now);
      req_item_type it;
      it                 = '0;
      it.op              = op;
      it.now_ms          = now;
      it.profile_ok      = 1'b1;
      it.stop_released   = 1'b1;
      it.sensor_ok       = 1'b1;
      it.current_ceiling = 16'hFFFF;
      return it;
   endfunction

   // Random item that keeps the interlock out of its terminal modes: no
   // e-stop, no fault op, no overcurrent or hard timeout while pulsing.
   function automatic req_item_type live_item();
      req_item_type it;
      int unsigned  pick;
      logic [31:0]  run_ms;
      it.op               = OP_TICK;
      it.profile_ok       = ($urandom_range(0, 9) != 0);
      it.stop_released    = ($urandom_range(0, 9) != 0);
      it.probe_kind       = 1'($urandom_range(0, 1));
      it.sensor_ok        = ($urandom_range(0, 7) != 0);
      it.current_ceiling  = 16'($urandom);
      it.current_measured = 16'($urandom);
      it.stop_pressed     = 1'b0;
      clock_ms += $urandom_range(0, 30);
      it.now_ms = clock_ms;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         it.op     = ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
         it.now_ms = $urandom;
         return it;
      end
      case (sb.mode)
         MC_PULSING: it.op = pick < 70 ? OP_TICK : pick < 80 ? OP_FINISH :
                             pick < 92 ? OP_START : OP_ARM;
         MC_UNARMED: it.op = pick < 60 ? OP_ARM : pick < 75 ? OP_START :
                             pick < 90 ? OP_TICK : OP_FINISH;
         default:    it.op = pick < 55 ? OP_START : pick < 80 ? OP_TICK :
                             pick < 93 ? OP_FINISH : OP_ARM;
      endcase
      if (it.op == OP_ARM) it.now_ms = $urandom;
      if (it.op == OP_TICK && sb.mode == MC_PULSING) begin
         it.current_measured = 16'($urandom_range(0, it.current_ceiling));
         run_ms = it.now_ms - sb.pulse_t0;
         if (sb.regs.max_run_ms == 0)
            it.op = OP_FINISH;
         else if (run_ms >= sb.regs.max_run_ms)
            it.now_ms = sb.pulse_t0 + $urandom_range(0, sb.regs.max_run_ms - 1);
      end
      return it;
   endfunction

   task automatic run_live(input int count, input int hold_at);
      for (int n = 0; n < count; n++) begin
         if (n == hold_at) hold_request = 1'b1;
         send_item(live_item());
      end
   endtask

   // --------------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------------
   initial begin : stimulus
      req_item_type it;
      int unsigned  ceil_v;
      repeat (12) @(posedge clock);
      reset     <= 1'b0;
      gap_pct   = 20;
      stall_pct = 20;

      // registers at reset values: every budget zero
      send_item(base_item(OP_START, 32'd0));
      it = base_item(OP_TICK, 32'hFFFF_FFFF);
      it.current_measured = 16'hFFFF;
      it.current_ceiling  = 16'h0000;
      send_item(it);
      send_item(base_item(OP_FINISH, 32'd7));
      send_item(base_item(OP_SPARE_LO, 32'd8));
      send_item(base_item(OP_SPARE_HI, 32'd9));
      it = base_item(OP_ARM, 32'd10);
      it.profile_ok = 1'b0;
      send_item(it);
      it = base_item(OP_ARM, 32'd11);
      it.stop_released = 1'b0;
      send_item(it);
      send_item(base_item(OP_ARM, 32'd12));
      it = base_item(OP_START, 32'd13);
      it.sensor_ok = 1'b0;
      send_item(it);
      send_item(base_item(OP_START, 32'd14));
      req_valid <= 1'b0;
      wait_drained();

      // one full pulse cycle with the busy, cooldown, diagnostic and verification refusals
      set_config(32'd10, 32'd1000, 32'd20, 16'd3, 16'd1, 16'd1);
      send_item(base_item(OP_START, 32'd100));
      send_item(base_item(OP_START, 32'd101));
      it = base_item(OP_TICK, 32'd105);
      it.current_measured = 16'hFFFF;
      send_item(it);
      send_item(base_item(OP_TICK, 32'd110));
      send_item(base_item(OP_START, 32'd115));
      send_item(base_item(OP_START, 32'd130));
      it = base_item(OP_START, 32'd130);
      it.probe_kind = 1'b1;
      send_item(it);
      send_item(base_item(OP_FINISH, 32'd140));
      it = base_item(OP_START, 32'd160);
      it.probe_kind = 1'b1;
      send_item(it);
      send_item(base_item(OP_ARM, 32'd161));
      it = base_item(OP_START, 32'd162);
      it.probe_kind = 1'b1;
      send_item(it);
      send_item(base_item(OP_ARM, 32'd163));
      // pulse that spans the timestamp wrap
      send_item(base_item(OP_START, 32'hFFFF_FFF8));
      send_item(base_item(OP_TICK, 32'h0000_0002));
      req_valid <= 1'b0;
      wait_drained();

      // random phases
      set_config($urandom_range(0, 40), $urandom_range(100, 400), $urandom_range(0, 40),
                 16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                 16'($urandom_range(1, 6)));
      clock_ms = $urandom;
      gap_pct   = 25;
      stall_pct = 25;
      run_live(230, -1);
      req_valid <= 1'b0;
      wait_drained();

      set_config(32'd0, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      gap_pct   = 0;
      stall_pct = 30;
      run_live(230, -1);
      req_valid <= 1'b0;
      wait_drained();

      // register maxima, time base crossing the wrap, one long receiver hold
      set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                 16'($urandom_range(0, 4)));
      clock_ms  = 32'hFFFF_FC00;
      gap_pct   = 25;
      stall_pct = 25;
      run_live(230, 60);
      req_valid <= 1'b0;
      wait_drained();

      set_config($urandom_range(0, 40), $urandom_range(1, 300), $urandom_range(0, 50),
                 16'($urandom_range(0, 8)), 16'd0, 16'($urandom_range(0, 4)));
      clock_ms  = $urandom;
      gap_pct   = 30;
      stall_pct = 0;
      run_live(230, -1);
      req_valid <= 1'b0;
      wait_drained();

      // last part: back to back, no idling on either side
      set_config($urandom_range(0, 40), $urandom_range(60, 300), $urandom_range(0, 50),
                 16'($urandom_range(2, 8)), 16'($urandom_range(1, 4)),
                 16'($urandom_range(1, 4)));
      gap_pct   = 0;
      stall_pct = 0;
      run_live(230, -1);

      // terminal: one fault kind, then e-stop, then anything at all
      clock_ms += 5;
      send_item(base_item(OP_ARM, clock_ms));
      clock_ms += 5;
      it = base_item(OP_START, clock_ms);
      it.probe_kind = 1'($urandom_range(0, 1));
      send_item(it);
      case ($urandom_range(0, 2))
         0: begin
            ceil_v = $urandom_range(0, 16'hFFFE);
            it = base_item(OP_TICK, clock_ms + 1);
            it.current_ceiling  = 16'(ceil_v);
            it.current_measured = 16'($urandom_range(ceil_v + 1, 16'hFFFF));
            send_item(it);
         end
         1: begin
            it = base_item(OP_TICK, sb.pulse_t0 + sb.regs.max_run_ms);
            it.current_ceiling  = 16'($urandom);
            it.current_measured = 16'($urandom_range(0, it.current_ceiling));
            send_item(it);
         end
         default: send_item(base_item(OP_FAULT, clock_ms + 1));
      endcase
      it = base_item(OP_TICK, clock_ms + 2);
      it.stop_pressed = 1'b1;
      send_item(it);
      send_item(base_item(OP_ESTOP, clock_ms + 3));
      send_item(base_item(OP_ARM, clock_ms + 4));
      send_item(base_item(OP_START, clock_ms + 5));
      for (int n = 0; n < 30; n++) begin
         it.op               = 3'($urandom_range(0, 7));
         it.profile_ok       = 1'($urandom_range(0, 1));
         it.stop_released    = 1'($urandom_range(0, 1));
         it.probe_kind       = 1'($urandom_range(0, 1));
         it.now_ms           = $urandom;
         it.sensor_ok        = 1'($urandom_range(0, 1));
         it.current_measured = 16'($urandom);
         it.current_ceiling  = 16'($urandom);
         it.stop_pressed     = 1'($urandom_range(0, 1));
         send_item(it);
      end
      req_valid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);

      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/psi_pkg.sv
design/psi_csr.sv
design/psi_eval.sv
design/pulse_safety_interlock.sv
test/tb.sv
